// ===== rtl/mrst_pkg.sv =====
// ----------------------------------------------------------------------------
// mrst_pkg
// Shared types, codes and reset constants for the motor ripple stall tracker.
// ----------------------------------------------------------------------------
package mrst_pkg;

    localparam int NUM_MOTORS  = 5;
    localparam int MOTOR_IDX_W = 3;
    localparam int MODE_W      = 3;
    localparam int RIPPLE_W    = 16;
    localparam int POS_W       = 16;
    localparam int TIME_W      = 32;
    localparam int STAG_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // item modes
    localparam logic [MODE_W-1:0] MODE_FORWARD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BRAKE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NOP     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SAMPLE  = 3'd4;

    // stored direction
    localparam logic [1:0] DIR_FORWARD = 2'd0;
    localparam logic [1:0] DIR_REVERSE = 2'd1;
    localparam logic [1:0] DIR_BRAKE   = 2'd2;

    // motor status
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_MOVING  = 2'd1;
    localparam logic [1:0] ST_HOLDING = 2'd2;
    localparam logic [1:0] ST_STALLED = 2'd3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0  = 3'd3;

    localparam logic [15:0]       GRACE_RESET   = 16'd120;
    localparam logic [15:0]       STEP_RESET    = 16'd2;
    localparam logic [STAG_W-1:0] CONFIRM_RESET = 8'd3;
    localparam logic [POS_W-1:0]  LIMIT_RESET [NUM_MOTORS] =
        '{16'd10000, 16'd30000, 16'd30000, 16'd30000, 16'd30000};

    localparam logic [STAG_W-1:0] STAG_MAX = {STAG_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [1:0]          direction;
        logic [1:0]          status;
        logic [RIPPLE_W-1:0] last_ripples;
        logic [STAG_W-1:0]   stagnant;
        logic [TIME_W-1:0]   leg_start;
    } motor_rec_t;

    typedef struct packed {
        logic [15:0]       grace_ms;
        logic [15:0]       step_min;
        logic [STAG_W-1:0] confirm;
        logic [POS_W-1:0]  limit;
    } upd_cfg_t;

    typedef struct packed {
        logic accepted;
        logic stall_event;
    } upd_flags_t;

endpackage

// ===== rtl/mrst_update.sv =====
// ----------------------------------------------------------------------------
// mrst_update
// Next-state logic for one motor record: travel banking, leg start, brake and
// stall watchdog sample.
// ----------------------------------------------------------------------------
module mrst_update (
    input  logic [mrst_pkg::MODE_W-1:0]   mode,
    input  logic [mrst_pkg::RIPPLE_W-1:0] ripple_count,
    input  logic [mrst_pkg::TIME_W-1:0]   now_ms,
    input  mrst_pkg::upd_cfg_t            cfg,
    input  mrst_pkg::motor_rec_t          rec_cur,
    output mrst_pkg::motor_rec_t          rec_new,
    output mrst_pkg::upd_flags_t          flags
);
    import mrst_pkg::*;

    logic signed [POS_W+1:0]  pos_sum;
    logic [POS_W-1:0]         pos_banked;
    logic [TIME_W-1:0]        elapsed;
    logic [RIPPLE_W-1:0]      delta;
    logic [STAG_W-1:0]        stag_inc;
    logic                     watching;

    // bank ripples according to the direction in force before the command
    always_comb
    begin
        unique case (rec_cur.direction)
            DIR_FORWARD: pos_sum = $signed({2'b00, rec_cur.position})
                                 + $signed({2'b00, ripple_count});
            DIR_REVERSE: pos_sum = $signed({2'b00, rec_cur.position})
                                 - $signed({2'b00, ripple_count});
            default:     pos_sum = $signed({2'b00, rec_cur.position});
        endcase
        priority if (pos_sum < 0)
            pos_banked = '0;
        else if (pos_sum > $signed({2'b00, cfg.limit}))
            pos_banked = cfg.limit;
        else
            pos_banked = pos_sum[POS_W-1:0];
    end

    assign elapsed  = now_ms - rec_cur.leg_start;
    assign delta    = ripple_count - rec_cur.last_ripples;
    assign stag_inc = (rec_cur.stagnant != STAG_MAX) ? rec_cur.stagnant + 1'b1
                                                     : rec_cur.stagnant;
    assign watching = ((rec_cur.status == ST_MOVING) || (rec_cur.status == ST_STALLED))
                   && (elapsed >= {{(TIME_W-16){1'b0}}, cfg.grace_ms});

    always_comb
    begin
        rec_new           = rec_cur;
        flags.accepted    = 1'b0;
        flags.stall_event = 1'b0;
        unique case (mode)
            MODE_FORWARD, MODE_REVERSE:
            begin
                flags.accepted       = 1'b1;
                rec_new.position     = pos_banked;
                rec_new.direction    = (mode == MODE_FORWARD) ? DIR_FORWARD : DIR_REVERSE;
                rec_new.status       = ST_MOVING;
                rec_new.last_ripples = '0;
                rec_new.stagnant     = '0;
                rec_new.leg_start    = now_ms;
            end
            MODE_BRAKE:
            begin
                flags.accepted    = 1'b1;
                rec_new.position  = pos_banked;
                rec_new.direction = DIR_BRAKE;
                rec_new.status    = (pos_banked != '0) ? ST_HOLDING : ST_IDLE;
            end
            MODE_SAMPLE:
            begin
                flags.accepted = 1'b1;
                if (watching)
                begin
                    if (delta >= cfg.step_min)
                    begin
                        rec_new.last_ripples = ripple_count;
                        rec_new.stagnant     = '0;
                        rec_new.status       = ST_MOVING;
                    end
                    else
                    begin
                        rec_new.stagnant = stag_inc;
                        if (stag_inc >= cfg.confirm)
                        begin
                            flags.stall_event = (rec_cur.status != ST_STALLED);
                            rec_new.status    = ST_STALLED;
                        end
                    end
                end
            end
            default:
            begin
                // no-op and unused modes leave the record alone
                rec_new = rec_cur;
            end
        endcase
    end

endmodule

// ===== rtl/motor_ripple_stall_tracker.sv =====
// ----------------------------------------------------------------------------
// motor_ripple_stall_tracker
// Per-motor position bookkeeping and stall watchdog for five motors.
// ----------------------------------------------------------------------------
// Pipeline: input reg, then result reg; a held result stalls the input reg.
// Throughput: 1 item per cycle while out_ready is high; the record update
//   is one register-to-register pass, so back-to-back items on the same
//   motor see the updated record.
// Reset: async active low; config returns to defaults, all motors idle at
//   position 0 with brake direction, pipeline empty. No clearing pass.
// ----------------------------------------------------------------------------
module motor_ripple_stall_tracker (
    input  logic                             clk,
    input  logic                             rst_n,

    // config write port
    input  logic                             cfg_wr_en,
    input  logic [mrst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrst_pkg::CFG_DATA_W-1:0]  cfg_data,

    // item input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mrst_pkg::MODE_W-1:0]      mode,
    input  logic [mrst_pkg::MOTOR_IDX_W-1:0] motor_index,
    input  logic [mrst_pkg::RIPPLE_W-1:0]    ripple_count,
    input  logic [mrst_pkg::TIME_W-1:0]      now_ms,

    // result output
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             accepted,
    output logic [1:0]                       motor_status,
    output logic [mrst_pkg::POS_W-1:0]       position_ripples,
    output logic                             stall_event
);
    import mrst_pkg::*;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [15:0]       grace_reg;
    logic [15:0]       step_reg;
    logic [STAG_W-1:0] confirm_reg;
    logic [POS_W-1:0]  limit_reg [NUM_MOTORS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg   <= GRACE_RESET;
            step_reg    <= STEP_RESET;
            confirm_reg <= CONFIRM_RESET;
            for (int m = 0; m < NUM_MOTORS; m++)
                limit_reg[m] <= LIMIT_RESET[m];
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_GRACE)
                grace_reg <= cfg_data;
            if (cfg_index == CFG_STEP)
                step_reg <= cfg_data;
            if (cfg_index == CFG_CONFIRM)
                confirm_reg <= cfg_data[STAG_W-1:0];
            for (int m = 0; m < NUM_MOTORS; m++)
                if (cfg_index == CFG_IDX_W'(CFG_LIMIT0 + m))
                    limit_reg[m] <= cfg_data[POS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register -> update -> result register.
    // The input stage advances whenever the result slot is free or being
    // taken this cycle; a held result blocks a fresh transfer only once
    // the input stage is full as well.
    // ------------------------------------------------------------------
    logic                   s1_valid_reg;
    logic [MODE_W-1:0]      s1_mode_reg;
    logic [MOTOR_IDX_W-1:0] s1_idx_reg;
    logic [RIPPLE_W-1:0]    s1_rip_reg;
    logic [TIME_W-1:0]      s1_now_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   s1_fire;

    assign advance  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg <= mode;
            s1_idx_reg  <= motor_index;
            s1_rip_reg  <= ripple_count;
            s1_now_reg  <= now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Motor records: five small records in flops, read by index
    // ------------------------------------------------------------------
    motor_rec_t motor_reg [NUM_MOTORS];
    motor_rec_t rec_cur;
    motor_rec_t rec_new;
    upd_flags_t flags;
    upd_cfg_t   upd_cfg;
    logic       idx_ok;

    assign idx_ok = (s1_idx_reg < MOTOR_IDX_W'(NUM_MOTORS));

    always_comb
    begin
        rec_cur         = '0;
        upd_cfg.limit   = '0;
        upd_cfg.grace_ms = grace_reg;
        upd_cfg.step_min = step_reg;
        upd_cfg.confirm  = confirm_reg;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            if (s1_idx_reg == MOTOR_IDX_W'(m))
            begin
                rec_cur       = motor_reg[m];
                upd_cfg.limit = limit_reg[m];
            end
        end
    end

    mrst_update u_update (
        .mode         (s1_mode_reg),
        .ripple_count (s1_rip_reg),
        .now_ms       (s1_now_reg),
        .cfg          (upd_cfg),
        .rec_cur      (rec_cur),
        .rec_new      (rec_new),
        .flags        (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                motor_reg[m].position     <= '0;
                motor_reg[m].direction    <= DIR_BRAKE;
                motor_reg[m].status       <= ST_IDLE;
                motor_reg[m].last_ripples <= '0;
                motor_reg[m].stagnant     <= '0;
                motor_reg[m].leg_start    <= '0;
            end
        end
        else if (s1_fire)
        begin
            for (int m = 0; m < NUM_MOTORS; m++)
                if (s1_idx_reg == MOTOR_IDX_W'(m))
                    motor_reg[m] <= rec_new;
        end
    end

    // ------------------------------------------------------------------
    // Result register; out-of-range motor reports all zero
    // ------------------------------------------------------------------
    logic             acc_reg;
    logic [1:0]       status_reg;
    logic [POS_W-1:0] pos_reg;
    logic             event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            acc_reg    <= idx_ok && flags.accepted;
            status_reg <= idx_ok ? rec_new.status : ST_IDLE;
            pos_reg    <= idx_ok ? rec_new.position : '0;
            event_reg  <= idx_ok && flags.stall_event;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = acc_reg;
    assign motor_status     = status_reg;
    assign position_ripples = pos_reg;
    assign stall_event      = event_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_event_means_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stall_event |-> (motor_status == ST_STALLED) && accepted)
        else $error("stall event without stalled status");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_idx_reg)
                                     && $stable(s1_now_reg))
        else $error("input stage lost or changed a stalled item");

    a_result_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("item left input stage without a result");

    for (genvar g = 0; g < NUM_MOTORS; g++)
    begin : g_rec_chk
        a_holding_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
            motor_reg[g].status == ST_HOLDING |-> motor_reg[g].position != '0)
            else $error("holding motor at position zero");

        a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
            motor_reg[g].direction != 2'd3)
            else $error("illegal stored direction");
    end

endmodule
